### src/page_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// page free list allocator assertion macros
// shared helpers for concurrent checks, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH

// condition holds in the same cycle
`define PFLA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfla assertion failed");

// condition holds in the following cycle
`define PFLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfla assertion failed");

`endif

### src/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// shared types and constants of the page free list allocator
// ----------------------------------------------------------------------------
package pfla_pkg;

   localparam int ADDR_W         = 32;
   localparam int TOTAL_W        = 13;
   localparam int USE_W          = 14;
   localparam int CNT_LIMIT      = 8191;
   localparam int DEF_MAX_PAGES  = 4096;
   localparam int DEF_PAGE_BYTES = 4096;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_BAD_ADR = 2'd2
   } status_type;

   typedef enum logic {
      CSR_LOW_LIMIT  = 1'b0,
      CSR_HIGH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_INIT_BASE,
      FSM_INIT_CNT,
      FSM_INIT_WALK
   } fsm_type;

endpackage

### src/pfla_ram.sv
// ----------------------------------------------------------------------------
// pfla_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pfla_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator
// lifo physical page allocator; free list kept as a head entry plus one
// next link per page slot in a synchronous ram
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// req_      in         start & !busy          operation, address
// rsp_      out        rsp_valid, one cycle   page_address, status, counts
// csr_      in         csr_valid & csr_ready  csr_index, csr_data
//
// allocate, free and no-op end in the execute state, using the registered
// link ram read at the head slot; initialize goes on through base, count
// and walk states, n pages written to the link ram one a cycle
// reset is synchronous, the link ram needs no clearing pass
// the result strobe cannot be held off; busy stays high until it is shown
// ----------------------------------------------------------------------------
module page_free_list_allocator
   import pfla_pkg::*;
#(
   parameter int MAX_PAGES  = DEF_MAX_PAGES,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_operation,
   input  logic [ADDR_W-1:0]        req_address,
   output logic                     rsp_valid,
   output logic [ADDR_W-1:0]        rsp_page_address,
   output logic [1:0]               rsp_status,
   output logic signed [USE_W-1:0]  rsp_pages_in_use,
   output logic [TOTAL_W-1:0]       rsp_pages_total,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [ADDR_W-1:0]        csr_data
);

`include "page_free_list_allocator_macros.svh"

   localparam int IDX_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int PG_SH     = $clog2(PAGE_BYTES);
   localparam int PG_W      = ADDR_W - PG_SH;
   localparam int LINK_W    = IDX_W + 1;
   localparam int COUNT_CAP = (MAX_PAGES < CNT_LIMIT) ? MAX_PAGES : CNT_LIMIT;

   localparam logic signed [USE_W-1:0] USE_CAP = USE_W'(COUNT_CAP);
   localparam logic signed [USE_W-1:0] USE_MIN = -USE_CAP;
   localparam logic [PG_W:0]           N_CAP   = (PG_W + 1)'(COUNT_CAP);
   localparam logic [ADDR_W:0]         PG_MASK = (ADDR_W + 1)'(PAGE_BYTES - 1);
   localparam logic [ADDR_W:0]         MAX_W   = (ADDR_W + 1)'(MAX_PAGES);

   fsm_type                    state_ff, state_in;
   op_type                     op_ff;
   logic [ADDR_W-1:0]          addr_ff;
   logic [ADDR_W-1:0]          low_ff, high_ff;
   logic [PG_W:0]              base_pg_ff, base_pg_in;
   logic                       head_valid_ff, head_valid_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic signed [USE_W-1:0]    in_use_ff, in_use_in;
   logic [TOTAL_W-1:0]         total_ff, total_in;
   logic [TOTAL_W-1:0]         walk_ff, walk_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]          rsp_page_ff, rsp_page_in;
   status_type                 rsp_status_ff, rsp_status_in;

   logic                       accept;
   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   logic [LINK_W-1:0]          ram_wr_data;
   logic [LINK_W-1:0]          ram_rd_data;

   logic [ADDR_W:0]            base_sum;
   logic [PG_W:0]              high_pg;
   logic [PG_W:0]              n_diff;
   logic [PG_W:0]              addr_pg;
   logic [PG_W:0]              free_diff;
   logic                       free_ok;
   logic                       free_tracked;
   logic [IDX_W-1:0]           free_slot;
   logic [PG_W:0]              alloc_pg;
   logic signed [USE_W-1:0]    use_inc, use_dec;

   assign accept    = start && (state_ff == FSM_IDLE);
   assign busy      = (state_ff != FSM_IDLE);
   assign csr_ready = (state_ff == FSM_IDLE);

   pfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // address arithmetic
   assign base_sum     = {1'b0, low_ff} + PG_MASK;
   assign high_pg      = {1'b0, high_ff[ADDR_W-1:PG_SH]};
   assign n_diff       = high_pg - base_pg_ff;
   assign addr_pg      = {1'b0, addr_ff[ADDR_W-1:PG_SH]};
   assign free_diff    = addr_pg - base_pg_ff;
   assign free_ok      = (addr_ff[PG_SH-1:0] == '0) && (addr_ff >= low_ff)
                         && (addr_ff < high_ff);
   assign free_tracked = (addr_pg >= base_pg_ff)
                         && ((ADDR_W + 1)'(free_diff) < MAX_W);
   assign free_slot    = IDX_W'(free_diff);
   assign alloc_pg     = base_pg_ff + (PG_W + 1)'(head_ff);
   assign use_inc      = (in_use_ff >= USE_CAP) ? USE_CAP : in_use_ff + USE_W'(1);
   assign use_dec      = (in_use_ff <= USE_MIN) ? USE_MIN : in_use_ff - USE_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (op_ff == OP_INIT) begin
               state_in = FSM_INIT_BASE;
            end else begin
               state_in = FSM_IDLE;
            end
         end
         FSM_INIT_BASE: state_in = FSM_INIT_CNT;
         FSM_INIT_CNT:  state_in = FSM_INIT_WALK;
         FSM_INIT_WALK: begin
            if (walk_ff == total_ff) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      base_pg_in    = base_pg_ff;
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      in_use_in     = in_use_ff;
      total_in      = total_ff;
      walk_in       = walk_ff;
      rsp_valid_in  = 1'b0;
      rsp_page_in   = '0;
      rsp_status_in = ST_OK;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = free_slot;
      ram_wr_data   = {head_valid_ff, head_ff};
      case (state_ff)
         FSM_EXEC: begin
            case (op_ff)
               OP_ALLOC: begin
                  rsp_valid_in = 1'b1;
                  if (head_valid_ff) begin
                     rsp_page_in   = {alloc_pg[PG_W-1:0], {PG_SH{1'b0}}};
                     head_valid_in = ram_rd_data[IDX_W];
                     head_in       = ram_rd_data[IDX_W-1:0];
                     in_use_in     = use_inc;
                  end else begin
                     rsp_status_in = ST_EMPTY;
                  end
               end
               OP_FREE: begin
                  rsp_valid_in = 1'b1;
                  if (!free_ok) begin
                     rsp_status_in = ST_BAD_ADR;
                  end else begin
                     in_use_in = use_dec;
                     if (free_tracked) begin
                        ram_wr_en     = 1'b1;
                        head_valid_in = 1'b1;
                        head_in       = free_slot;
                     end
                  end
               end
               OP_INIT: begin
                  rsp_valid_in = 1'b0;
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         FSM_INIT_BASE: begin
            base_pg_in = base_sum[ADDR_W:PG_SH];
         end
         FSM_INIT_CNT: begin
            if (base_pg_ff <= high_pg) begin
               total_in = (n_diff > N_CAP) ? TOTAL_W'(COUNT_CAP) : TOTAL_W'(n_diff);
            end else begin
               total_in = '0;
            end
            in_use_in     = '0;
            head_valid_in = 1'b0;
            walk_in       = '0;
         end
         FSM_INIT_WALK: begin
            if (walk_ff == total_ff) begin
               rsp_valid_in  = 1'b1;
               head_valid_in = (total_ff != '0);
               head_in       = IDX_W'(total_ff - TOTAL_W'(1));
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = IDX_W'(walk_ff);
               ram_wr_data = {(walk_ff != '0), IDX_W'(walk_ff - TOTAL_W'(1))};
               walk_in     = walk_ff + TOTAL_W'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         low_ff        <= '0;
         high_ff       <= '0;
         base_pg_ff    <= '0;
         head_valid_ff <= 1'b0;
         head_ff       <= '0;
         in_use_ff     <= '0;
         total_ff      <= '0;
         walk_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_pg_ff    <= base_pg_in;
         head_valid_ff <= head_valid_in;
         head_ff       <= head_in;
         in_use_ff     <= in_use_in;
         total_ff      <= total_in;
         walk_ff       <= walk_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LOW_LIMIT:  low_ff  <= csr_data;
               CSR_HIGH_LIMIT: high_ff <= csr_data;
               default:        low_ff  <= low_ff;
            endcase
         end
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_operation);
         addr_ff <= req_address;
      end
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_page_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pages_in_use = in_use_ff;
   assign rsp_pages_total  = total_ff;

   `PFLA_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `PFLA_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == FSM_IDLE)
   `PFLA_ASSERT_SAME(a_empty_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_page_ff == '0)
   `PFLA_ASSERT_SAME(a_use_bounds, clock, reset, 1'b1,
      (in_use_ff <= USE_CAP) && (in_use_ff >= USE_MIN))

endmodule
